// ===== hdl/lkr_pkg.sv =====
package lkr_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int RETRY_W         = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES        = 2'd3;

  localparam logic [15:0]        RETRY_INTERVAL_RST     = 16'd1000;
  localparam logic [15:0]        HEARTBEAT_TIMEOUT_RST  = 16'd5000;
  localparam logic [15:0]        HEARTBEAT_INTERVAL_RST = 16'd1000;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST        = 8'd3;

  localparam logic [2:0] MODE_TICK        = 3'd0;
  localparam logic [2:0] MODE_OPEN_INIT   = 3'd1;
  localparam logic [2:0] MODE_OPEN_REQ    = 3'd2;
  localparam logic [2:0] MODE_ACCEPT_RX   = 3'd3;
  localparam logic [2:0] MODE_HB_RX       = 3'd4;
  localparam logic [2:0] MODE_CLOSE       = 3'd5;
  localparam logic [2:0] MODE_FORCE_CLOSE = 3'd6;

  localparam logic [2:0] SEND_NONE = 3'd0;
  localparam logic [2:0] SEND_REQ  = 3'd1;
  localparam logic [2:0] SEND_ACC  = 3'd2;
  localparam logic [2:0] SEND_HB   = 3'd3;
  localparam logic [2:0] SEND_DISC = 3'd4;

  typedef enum logic [1:0] {
    LS_DOWN = 2'd0,
    LS_CONN = 2'd1,
    LS_UP   = 2'd2
  } link_state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] elapsed;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic [2:0] send_kind;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]        retry_interval;
    logic [15:0]        heartbeat_timeout;
    logic [15:0]        heartbeat_interval;
    logic [RETRY_W-1:0] max_retries;
  } cfg_t;

endpackage

// ===== hdl/link_keepalive_retry_fsm.sv =====
// Keepalive state machine for one link (down, connecting, up).
// Input channel in_valid/in_ready/in_data carries one event per beat: a mode
// code and, for a tick, the elapsed tick count. Every event yields exactly one
// result beat on out_valid/out_ready/out_data with the link state after the
// event and the control packet to send.
// The configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// retry interval, heartbeat timeout, heartbeat interval and retry budget; it
// is always ready and should only be used while no events are in flight.
// The event is held in an input register, and the state update and result are
// computed combinationally from it into the result register. One event per
// cycle is sustained while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more event, so in_ready drops only when both are
// full. Reset clears both stages, puts the link down with all timers and the
// retry budget at zero, and restores the register defaults.
module link_keepalive_retry_fsm #(
  parameter int TIMER_WIDTH = lkr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lkr_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lkr_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lkr_pkg::CFG_DATA_W-1:0] cfg_data
);

  lkr_pkg::cfg_t      cfg;
  lkr_pkg::in_beat_t  in_r;
  lkr_pkg::out_beat_t out_r;
  lkr_pkg::out_beat_t core_res;
  logic               in_valid_r;
  logic               out_valid_r;
  logic               out_free;
  logic               adv;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign adv       = in_valid_r && out_free;
  assign in_ready  = !in_valid_r || out_free;

  lkr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  lkr_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ev_en (adv),
    .ev    (in_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("event beat lost between stages");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full");

  a_disc_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.send_kind == lkr_pkg::SEND_DISC)
    |-> (out_r.link_state == lkr_pkg::LS_DOWN))
    else $error("disconnect sent while link is not down");

endmodule

// ===== hdl/lkr_cfg_regs.sv =====
module lkr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [lkr_pkg::CFG_IDX_W-1:0]     wr_idx,
  input  logic [lkr_pkg::CFG_DATA_W-1:0]    wr_data,
  output lkr_pkg::cfg_t                     cfg
);

  lkr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_interval     <= lkr_pkg::RETRY_INTERVAL_RST;
      cfg_r.heartbeat_timeout  <= lkr_pkg::HEARTBEAT_TIMEOUT_RST;
      cfg_r.heartbeat_interval <= lkr_pkg::HEARTBEAT_INTERVAL_RST;
      cfg_r.max_retries        <= lkr_pkg::MAX_RETRIES_RST;
    end else if (wr_en) begin
      case (wr_idx)
        lkr_pkg::CFG_RETRY_INTERVAL:     cfg_r.retry_interval     <= wr_data;
        lkr_pkg::CFG_HEARTBEAT_TIMEOUT:  cfg_r.heartbeat_timeout  <= wr_data;
        lkr_pkg::CFG_HEARTBEAT_INTERVAL: cfg_r.heartbeat_interval <= wr_data;
        lkr_pkg::CFG_MAX_RETRIES: begin
          cfg_r.max_retries <= wr_data[lkr_pkg::RETRY_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/lkr_core.sv =====
module lkr_core #(
  parameter int TIMER_WIDTH = lkr_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ev_en,
  input  lkr_pkg::in_beat_t ev,
  input  lkr_pkg::cfg_t     cfg,
  output lkr_pkg::out_beat_t res
);

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  lkr_pkg::link_state_t             state_r, state_nxt;
  logic [TIMER_WIDTH-1:0]           timeout_r, timeout_nxt;
  logic [TIMER_WIDTH-1:0]           hb_r, hb_nxt;
  logic [lkr_pkg::RETRY_W-1:0]      retries_r, retries_nxt;

  logic [TIMER_WIDTH-1:0] retry_ld, hbto_ld, hbint_ld;
  logic [CMP_W-1:0]       to_ext, hb_ext, el_ext;
  logic [TIMER_WIDTH-1:0] to_sub, hb_sub;
  logic [2:0]             send;

  assign retry_ld = (TIMER_WIDTH)'(cfg.retry_interval);
  assign hbto_ld  = (TIMER_WIDTH)'(cfg.heartbeat_timeout);
  assign hbint_ld = (TIMER_WIDTH)'(cfg.heartbeat_interval);

  // Both timers count down by the elapsed ticks and stop at zero.
  assign to_ext = (CMP_W)'(timeout_r);
  assign hb_ext = (CMP_W)'(hb_r);
  assign el_ext = (CMP_W)'(ev.elapsed);
  assign to_sub = (to_ext > el_ext) ? (TIMER_WIDTH)'(to_ext - el_ext) : '0;
  assign hb_sub = (hb_ext > el_ext) ? (TIMER_WIDTH)'(hb_ext - el_ext) : '0;

  always_comb begin
    state_nxt   = state_r;
    timeout_nxt = timeout_r;
    hb_nxt      = hb_r;
    retries_nxt = retries_r;
    send        = lkr_pkg::SEND_NONE;
    case (ev.mode)
      lkr_pkg::MODE_TICK: begin
        timeout_nxt = to_sub;
        case (state_r)
          lkr_pkg::LS_CONN: begin
            if (to_sub == '0) begin
              if (retries_r == '0) begin
                state_nxt = lkr_pkg::LS_DOWN;
              end else begin
                retries_nxt = retries_r - 1'b1;
                timeout_nxt = retry_ld;
                send        = lkr_pkg::SEND_REQ;
              end
            end
          end
          lkr_pkg::LS_UP: begin
            if (to_sub == '0) begin
              state_nxt = lkr_pkg::LS_DOWN;
            end else if (hb_sub == '0) begin
              hb_nxt = hbint_ld;
              send   = lkr_pkg::SEND_HB;
            end else begin
              hb_nxt = hb_sub;
            end
          end
          default: ;
        endcase
      end
      lkr_pkg::MODE_OPEN_INIT: begin
        state_nxt   = lkr_pkg::LS_CONN;
        timeout_nxt = retry_ld;
        retries_nxt = cfg.max_retries;
        send        = lkr_pkg::SEND_REQ;
      end
      lkr_pkg::MODE_OPEN_REQ: begin
        state_nxt   = lkr_pkg::LS_UP;
        hb_nxt      = hbint_ld;
        timeout_nxt = hbto_ld;
        retries_nxt = cfg.max_retries;
        send        = lkr_pkg::SEND_ACC;
      end
      lkr_pkg::MODE_ACCEPT_RX: begin
        state_nxt   = lkr_pkg::LS_UP;
        timeout_nxt = hbto_ld;
        if (state_r != lkr_pkg::LS_UP) begin
          hb_nxt = hbint_ld;
        end
      end
      lkr_pkg::MODE_HB_RX: begin
        timeout_nxt = hbto_ld;
      end
      lkr_pkg::MODE_CLOSE: begin
        state_nxt = lkr_pkg::LS_DOWN;
        send      = lkr_pkg::SEND_DISC;
      end
      lkr_pkg::MODE_FORCE_CLOSE: begin
        state_nxt = lkr_pkg::LS_DOWN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lkr_pkg::LS_DOWN;
      timeout_r <= '0;
      hb_r      <= '0;
      retries_r <= '0;
    end else if (ev_en) begin
      state_r   <= state_nxt;
      timeout_r <= timeout_nxt;
      hb_r      <= hb_nxt;
      retries_r <= retries_nxt;
    end
  end

  assign res.link_state = state_nxt;
  assign res.send_kind  = send;

  a_req_from_conn: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_en && send == lkr_pkg::SEND_REQ) |=> (state_r == lkr_pkg::LS_CONN))
    else $error("connect request sent outside connecting state");

  a_hb_while_up: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_en && (send == lkr_pkg::SEND_HB || send == lkr_pkg::SEND_ACC))
    |=> (state_r == lkr_pkg::LS_UP && timeout_r != '0 || hbto_ld == '0))
    else $error("heartbeat or accept sent while link is not up");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ev_en |=> ($stable(state_r) && $stable(timeout_r) && $stable(retries_r)))
    else $error("link state changed without an event");

  a_retry_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_en && ev.mode == lkr_pkg::MODE_TICK && send == lkr_pkg::SEND_REQ)
    |=> (retries_r == $past(retries_r) - 1'b1))
    else $error("retry budget not consumed by a resent request");

endmodule
